// ----- hdl/hkmc_pkg.sv -----
// shared types and constants for the hunt-and-kill maze carver
package hkmc_pkg;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  localparam logic [3:0] ALL_DIRS = 4'hf;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DRAW  = 1'b1;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  localparam int CFG_W = 7;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic mark_walker;
    logic mark_next;
    logic probe_issue;
    logic probe_sel;
    logic self_issue;
    logic scan_init;
    logic scan_next;
    logic take_scan;
    logic emit_walk;
    logic emit_fin;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic probe_last;
    logic nb_free;
    logic nb_vis_any;
    logic dir_free;
    logic dir_vis;
    logic self_vis;
    logic scan_last;
    logic out_full;
  } sts_t;

endpackage

// ----- hdl/hunt_and_kill_maze_carver.sv -----
// top level of the hunt-and-kill maze carver with its configuration registers
//
// Input channel (in_valid/in_ready): one beat is a start item (kind 0, with
// start_x/start_y) or a direction draw (kind 1, with draw_dir). Output channel
// (out_valid/out_ready): at most one beat per draw, giving the opened wall, or
// a finished beat when the hunt finds no cell left. Configuration channel
// (cfg_valid/cfg_ready, always ready): index 0 sets maze_width, 1 maze_height.
// The block takes one item at a time; in_ready is high only while it waits.
// A start item clears the whole visited map, one entry a cycle through the
// single write port. A walk draw reads the four neighbors through the single
// read port before it returns its beat. A draw that starts a hunt reads each
// scanned cell and, for an unvisited one, its neighbors, column by column;
// rejected draws end with no beat. Reset clears the controller, sets both
// registers to 16 and leaves the block done, so draws are ignored until a
// start item. When the receiver stalls, the pending beat is held in the
// result register; the next item is still taken and only waits if it has a
// beat of its own to deliver.
module hunt_and_kill_maze_carver #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic [5:0]                   start_x,
  input  logic [5:0]                   start_y,
  input  logic [1:0]                   draw_dir,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [5:0]                   from_x,
  output logic [5:0]                   from_y,
  output logic [1:0]                   opened_dir,
  output logic                         finished,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [0:0]                   cfg_index,
  input  logic [hkmc_pkg::CFG_W-1:0]   cfg_data
);
  import hkmc_pkg::*;

  localparam int EWA = $clog2(MAX_WIDTH + 1);
  localparam int EHA = $clog2(MAX_HEIGHT + 1);
  localparam int EWB = (EWA > EHA) ? EWA : EHA;
  localparam int EW  = (EWB > CFG_W) ? EWB : CFG_W;

  logic [CFG_W-1:0] maze_width;
  logic [CFG_W-1:0] maze_height;
  logic [EW-1:0]    cw_e;
  logic [EW-1:0]    ch_e;
  logic [EW-1:0]    eff_w;
  logic [EW-1:0]    eff_h;
  cmd_t             cmd;
  sts_t             sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      maze_width  <= CFG_W'(16);
      maze_height <= CFG_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:  maze_width  <= cfg_data;
        REG_HEIGHT: maze_height <= cfg_data;
      endcase
    end
  end

  // out-of-range sizes fold to the nearest legal value
  assign cw_e  = EW'(maze_width);
  assign ch_e  = EW'(maze_height);
  assign eff_w = (cw_e < EW'(2)) ? EW'(2) :
                 (cw_e > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : cw_e;
  assign eff_h = (ch_e < EW'(2)) ? EW'(2) :
                 (ch_e > EW'(MAX_HEIGHT)) ? EW'(MAX_HEIGHT) : ch_e;

  hkmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_kind  (kind),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  hkmc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .EW         (EW)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .in_kind    (kind),
    .start_x    (start_x),
    .start_y    (start_y),
    .draw_dir   (draw_dir),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .from_x     (from_x),
    .from_y     (from_y),
    .opened_dir (opened_dir),
    .finished   (finished)
  );

endmodule

// ----- hdl/hkmc_datapath.sv -----
// visited map, walker and scan registers, neighbor probing and result register
module hkmc_datapath #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int EW         = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  hkmc_pkg::cmd_t      cmd,
  output hkmc_pkg::sts_t      sts,
  input  logic [EW-1:0]       eff_w,
  input  logic [EW-1:0]       eff_h,
  input  logic                in_kind,
  input  logic [5:0]          start_x,
  input  logic [5:0]          start_y,
  input  logic [1:0]          draw_dir,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [5:0]          from_x,
  output logic [5:0]          from_y,
  output logic [1:0]          opened_dir,
  output logic                finished
);
  import hkmc_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2 ** AW;
  localparam int PX    = (XW > 6) ? XW : 6;
  localparam int PY    = (YW > 6) ? YW : 6;

  typedef struct packed {
    logic          ok;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } nbr_t;

  function automatic nbr_t nbr(input logic [XW-1:0] x, input logic [YW-1:0] y,
                               input logic [1:0] d, input logic [EW-1:0] w,
                               input logic [EW-1:0] h);
    logic [EW-1:0] ex;
    logic [EW-1:0] ey;
    logic          ok;
    nbr_t          r;
    ex = EW'(x);
    ey = EW'(y);
    ok = 1'b1;
    unique case (d)
      DIR_N: begin
        if (y == '0) ok = 1'b0;
        else ey = ey - EW'(1);
      end
      DIR_E: ex = ex + EW'(1);
      DIR_S: ey = ey + EW'(1);
      DIR_W: begin
        if (x == '0) ok = 1'b0;
        else ex = ex - EW'(1);
      end
    endcase
    r.ok = ok && (ex < w) && (ey < h);
    r.x  = ex[XW-1:0];
    r.y  = ey[YW-1:0];
    return r;
  endfunction

  logic          mem [DEPTH];
  logic          rdata;
  logic          re;
  logic          we;
  logic          wdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  logic [XW-1:0] walker_x;
  logic [YW-1:0] walker_y;
  logic [XW-1:0] scan_x;
  logic [YW-1:0] scan_y;
  logic [1:0]    item_dir;
  logic [1:0]    k;
  logic          cap_en;
  logic [1:0]    cap_k;
  logic          cap_ok;
  logic [3:0]    nbok;
  logic [3:0]    nbv;
  logic [AW-1:0] clr_cnt;

  logic [XW-1:0] center_x;
  logic [YW-1:0] center_y;
  nbr_t          pn;
  nbr_t          wn;
  logic [EW-1:0] wm1;
  logic [EW-1:0] hm1;
  logic [EW-1:0] sx_e;
  logic [EW-1:0] sy_e;
  logic [EW-1:0] sx_c;
  logic [EW-1:0] sy_c;
  logic [PX-1:0] wx_e;
  logic [PY-1:0] wy_e;
  logic          y_wrap;

  assign wm1  = eff_w - EW'(1);
  assign hm1  = eff_h - EW'(1);
  assign sx_e = EW'(start_x);
  assign sy_e = EW'(start_y);
  assign sx_c = (sx_e > wm1) ? wm1 : sx_e;
  assign sy_c = (sy_e > hm1) ? hm1 : sy_e;
  assign wx_e = PX'(walker_x);
  assign wy_e = PY'(walker_y);
  assign y_wrap = (EW'(scan_y) == hm1);

  assign center_x = cmd.probe_sel ? scan_x : walker_x;
  assign center_y = cmd.probe_sel ? scan_y : walker_y;
  assign pn = nbr(center_x, center_y, k, eff_w, eff_h);
  assign wn = nbr(walker_x, walker_y, item_dir, eff_w, eff_h);

  // map ports
  assign re    = cmd.probe_issue | cmd.self_issue;
  assign raddr = cmd.self_issue ? {scan_y, scan_x} : {pn.y, pn.x};
  assign we    = cmd.clr_step | cmd.mark_walker | cmd.mark_next;
  assign wdata = !cmd.clr_step;

  always_comb begin
    priority if (cmd.clr_step) begin
      waddr = clr_cnt;
    end else if (cmd.mark_next) begin
      waddr = {wn.y, wn.x};
    end else begin
      waddr = {walker_y, walker_x};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_dir <= draw_dir;
      if (in_kind == KIND_START) begin
        walker_x <= sx_c[XW-1:0];
        walker_y <= sy_c[YW-1:0];
      end
    end else if (cmd.mark_next) begin
      walker_x <= wn.x;
      walker_y <= wn.y;
    end else if (cmd.take_scan) begin
      walker_x <= scan_x;
      walker_y <= scan_y;
    end
    if (cmd.scan_init) begin
      scan_x <= '0;
      scan_y <= '0;
    end else if (cmd.scan_next) begin
      if (y_wrap) begin
        scan_y <= '0;
        scan_x <= scan_x + XW'(1);
      end else begin
        scan_y <= scan_y + YW'(1);
      end
    end
    cap_k  <= k;
    cap_ok <= pn.ok;
    if (cap_en) begin
      nbok[cap_k] <= cap_ok;
      nbv[cap_k]  <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k       <= '0;
      clr_cnt <= '0;
      cap_en  <= 1'b0;
    end else begin
      cap_en <= cmd.probe_issue;
      if (cmd.load) begin
        k       <= '0;
        clr_cnt <= '0;
      end else begin
        if (cmd.probe_issue) k <= k + 2'd1;
        if (cmd.clr_step) clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_walk || cmd.emit_fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_walk) begin
      from_x     <= wx_e[5:0];
      from_y     <= wy_e[5:0];
      opened_dir <= item_dir;
      finished   <= 1'b0;
    end else if (cmd.emit_fin) begin
      from_x     <= '0;
      from_y     <= '0;
      opened_dir <= DIR_N;
      finished   <= 1'b1;
    end
  end

  assign sts.clr_last   = &clr_cnt;
  assign sts.probe_last = (k == 2'd3);
  assign sts.nb_free    = (~(nbok & ~nbv)) != ALL_DIRS;
  assign sts.nb_vis_any = (~(nbok & nbv)) != ALL_DIRS;
  assign sts.dir_free   = nbok[item_dir] & ~nbv[item_dir];
  assign sts.dir_vis    = nbok[item_dir] & nbv[item_dir];
  assign sts.self_vis   = rdata;
  assign sts.scan_last  = (EW'(scan_x) == wm1) && y_wrap;
  assign sts.out_full   = out_valid;

endmodule

// ----- hdl/hkmc_ctrl.sv -----
// sequencer for start, walk, hunt scan and result beats
module hkmc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_kind,
  output logic           in_ready,
  output hkmc_pkg::cmd_t cmd,
  input  hkmc_pkg::sts_t sts
);
  import hkmc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_MARK, S_PISSUE, S_PWAIT, S_WALK_EVAL, S_WALK_EMIT,
    S_SCAN_RD, S_SCAN_CHK, S_SCAN_EVAL, S_HUNT_EVAL, S_HUNT_EMIT, S_FIN_EMIT
  } state_t;

  typedef enum logic [1:0] {CTX_WALK, CTX_SCAN, CTX_HUNT} ctx_t;

  state_t state;
  state_t state_next;
  ctx_t   ctx;
  ctx_t   ctx_next;
  logic   hunting;
  logic   hunting_next;
  logic   maze_done;
  logic   maze_done_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    ctx_next       = ctx;
    hunting_next   = hunting;
    maze_done_next = maze_done;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (in_kind == KIND_START) begin
            hunting_next   = 1'b0;
            maze_done_next = 1'b0;
            state_next     = S_CLEAR;
          end else if (!maze_done) begin
            ctx_next   = hunting ? CTX_HUNT : CTX_WALK;
            state_next = S_PISSUE;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_MARK;
      end
      S_MARK: begin
        cmd.mark_walker = 1'b1;
        state_next      = S_IDLE;
      end
      S_PISSUE: begin
        cmd.probe_issue = 1'b1;
        cmd.probe_sel   = (ctx == CTX_SCAN);
        if (sts.probe_last) state_next = S_PWAIT;
      end
      S_PWAIT: begin
        unique case (ctx)
          CTX_WALK: state_next = S_WALK_EVAL;
          CTX_SCAN: state_next = S_SCAN_EVAL;
          default:  state_next = S_HUNT_EVAL;
        endcase
      end
      S_WALK_EVAL: begin
        priority if (!sts.nb_free) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN_RD;
        end else if (sts.dir_free) begin
          state_next = S_WALK_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WALK_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit_walk = 1'b1;
          cmd.mark_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        cmd.self_issue = 1'b1;
        state_next     = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        priority if (!sts.self_vis) begin
          ctx_next   = CTX_SCAN;
          state_next = S_PISSUE;
        end else if (sts.scan_last) begin
          state_next = S_FIN_EMIT;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_SCAN_EVAL: begin
        priority if (sts.nb_vis_any) begin
          cmd.take_scan = 1'b1;
          hunting_next  = 1'b1;
          state_next    = S_HUNT_EVAL;
        end else if (sts.scan_last) begin
          state_next = S_FIN_EMIT;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_HUNT_EVAL: begin
        state_next = sts.dir_vis ? S_HUNT_EMIT : S_IDLE;
      end
      S_HUNT_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit_walk   = 1'b1;
          cmd.mark_walker = 1'b1;
          hunting_next    = 1'b0;
          state_next      = S_IDLE;
        end
      end
      S_FIN_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit_fin   = 1'b1;
          maze_done_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ctx       <= CTX_WALK;
      hunting   <= 1'b0;
      maze_done <= 1'b1;
    end else begin
      state     <= state_next;
      ctx       <= ctx_next;
      hunting   <= hunting_next;
      maze_done <= maze_done_next;
    end
  end

`ifndef SYNTHESIS
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_walk || cmd.emit_fin) |-> !sts.out_full)
    else $error("result beat loaded while result register full");
  a_move_free: assert property (@(posedge clk) disable iff (rst)
    cmd.mark_next |-> sts.dir_free)
    else $error("walker moved into a visited or off-grid cell");
  a_join_seen: assert property (@(posedge clk) disable iff (rst)
    cmd.take_scan |-> sts.nb_vis_any)
    else $error("hunt took a cell with no visited neighbor");
  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_fin |=> (maze_done && state == S_IDLE))
    else $error("finished beat without ending the run");
  a_hunt_live: assert property (@(posedge clk) disable iff (rst)
    !(hunting && maze_done))
    else $error("hunting while maze is done");
`endif

endmodule

// ----- verif/tb.sv -----
// testbench for the hunt-and-kill maze carver: directed table, then random mazes checked by a predictor
module tb;
  import hkmc_pkg::*;

  localparam int MAX_W = 64;
  localparam int MAX_H = 64;
  localparam int QUIET_LIMIT = 200000;
  localparam int ITEM_GOAL = 1800;

  typedef struct packed {
    logic [5:0] fx;
    logic [5:0] fy;
    logic [1:0] od;
    logic       fin;
  } wall_t;

  typedef struct packed {
    bit         cfg;
    logic       kd;
    logic [5:0] sx;
    logic [5:0] sy;
    logic [1:0] d;
    logic [6:0] wv;
    logic [6:0] hv;
    bit         tp;
    bit         has;
    logic [5:0] fx;
    logic [5:0] fy;
    logic [1:0] od;
    logic       fin;
  } plan_row_t;

  localparam int NROWS = 28;
  // cfg, kind, start_x, start_y, dir, width, height, typed, has, from_x, from_y, wall, fin
  localparam plan_row_t PLAN [0:NROWS-1] = '{
    '{0, KIND_DRAW,   0,  0, DIR_N,   0,  0, 1, 0, 0, 0, DIR_N, 0},
    '{0, KIND_DRAW,  63, 63, DIR_W,   0,  0, 1, 0, 0, 0, DIR_N, 0},
    '{1, KIND_START,  0,  0, DIR_N,   0,  1, 0, 0, 0, 0, DIR_N, 0},
    '{0, KIND_START, 63, 63, DIR_N,   0,  0, 1, 0, 0, 0, DIR_N, 0},
    '{0, KIND_DRAW,   0,  0, DIR_E,   0,  0, 1, 0, 0, 0, DIR_N, 0},
    '{0, KIND_DRAW,   0,  0, DIR_S,   0,  0, 1, 0, 0, 0, DIR_N, 0},
    '{0, KIND_DRAW,   0,  0, DIR_N,   0,  0, 1, 1, 1, 1, DIR_N, 0},
    '{0, KIND_DRAW,   0,  0, DIR_N,   0,  0, 1, 0, 0, 0, DIR_N, 0},
    '{0, KIND_DRAW,   0,  0, DIR_W,   0,  0, 1, 1, 1, 0, DIR_W, 0},
    '{0, KIND_DRAW,   0,  0, DIR_S,   0,  0, 1, 1, 0, 0, DIR_S, 0},
    '{0, KIND_DRAW,   0,  0, DIR_E,   0,  0, 1, 1, 0, 0, DIR_N, 1},
    '{0, KIND_DRAW,   0,  0, DIR_S,   0,  0, 1, 0, 0, 0, DIR_N, 0},
    '{1, KIND_START,  0,  0, DIR_N,   3,  2, 0, 0, 0, 0, DIR_N, 0},
    '{0, KIND_START,  0,  0, DIR_N,   0,  0, 1, 0, 0, 0, DIR_N, 0},
    '{0, KIND_DRAW,   0,  0, DIR_E,   0,  0, 1, 1, 0, 0, DIR_E, 0},
    '{0, KIND_DRAW,   0,  0, DIR_S,   0,  0, 1, 1, 1, 0, DIR_S, 0},
    '{0, KIND_DRAW,   0,  0, DIR_W,   0,  0, 1, 1, 1, 1, DIR_W, 0},
    '{0, KIND_DRAW,   0,  0, DIR_N,   0,  0, 1, 0, 0, 0, DIR_N, 0},
    '{0, KIND_DRAW,   0,  0, DIR_E,   0,  0, 1, 0, 0, 0, DIR_N, 0},
    '{0, KIND_DRAW,   0,  0, DIR_S,   0,  0, 1, 0, 0, 0, DIR_N, 0},
    '{0, KIND_DRAW,   0,  0, DIR_W,   0,  0, 1, 1, 2, 0, DIR_W, 0},
    '{0, KIND_DRAW,   0,  0, DIR_S,   0,  0, 1, 1, 2, 0, DIR_S, 0},
    '{0, KIND_DRAW,   0,  0, DIR_N,   0,  0, 1, 1, 0, 0, DIR_N, 1},
    '{1, KIND_START,  0,  0, DIR_N, 127, 64, 0, 0, 0, 0, DIR_N, 0},
    '{0, KIND_START, 63, 63, DIR_N,   0,  0, 1, 0, 0, 0, DIR_N, 0},
    '{0, KIND_DRAW,   0,  0, DIR_E,   0,  0, 1, 0, 0, 0, DIR_N, 0},
    '{0, KIND_DRAW,   0,  0, DIR_N,   0,  0, 1, 1, 63, 63, DIR_N, 0},
    '{0, KIND_DRAW,   0,  0, DIR_W,   0,  0, 0, 0, 0, 0, DIR_N, 0}
  };

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             kind = KIND_START;
  logic [5:0]       start_x = '0;
  logic [5:0]       start_y = '0;
  logic [1:0]       draw_dir = DIR_N;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [5:0]       from_x;
  logic [5:0]       from_y;
  logic [1:0]       opened_dir;
  logic             finished;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [0:0]       cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor state
  bit [MAX_W*MAX_H-1:0] seen;
  int    cur_x;
  int    cur_y;
  bit    seeking;
  bit    carved_out = 1'b1;
  int    cols_reg = 16;
  int    rows_reg = 16;
  wall_t wall_q[$];

  int errors = 0;
  int n_items = 0;
  int n_walls = 0;
  int n_fin = 0;
  int n_cfg = 0;
  int snd_idle = 15;
  int rcv_idle = 63;
  int quiet = 0;

  hunt_and_kill_maze_carver #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .start_x   (start_x),
    .start_y   (start_y),
    .draw_dir  (draw_dir),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .from_x    (from_x),
    .from_y    (from_y),
    .opened_dir(opened_dir),
    .finished  (finished),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int cols();
    if (cols_reg < 2) return 2;
    if (cols_reg > MAX_W) return MAX_W;
    return cols_reg;
  endfunction

  function automatic int rows();
    if (rows_reg < 2) return 2;
    if (rows_reg > MAX_H) return MAX_H;
    return rows_reg;
  endfunction

  function automatic bit step_cell(input int x, input int y, input logic [1:0] d,
                                   output int nx, output int ny);
    nx = x;
    ny = y;
    case (d)
      DIR_N: begin
        if (y == 0) return 1'b0;
        ny = y - 1;
      end
      DIR_E: nx = x + 1;
      DIR_S: ny = y + 1;
      DIR_W: begin
        if (x == 0) return 1'b0;
        nx = x - 1;
      end
    endcase
    return nx < cols() && ny < rows();
  endfunction

  // a set bit marks a direction that is off the grid or whose cell is not in the wanted state
  function automatic logic [3:0] shut_dirs(input int x, input int y, input bit want);
    logic [3:0] m;
    int nx;
    int ny;
    m = '0;
    for (int d = 0; d < 4; d++) begin
      if (!step_cell(x, y, 2'(d), nx, ny) || seen[ny * MAX_W + nx] != want) m[d] = 1'b1;
    end
    return m;
  endfunction

  function automatic bit carve(input logic k, input logic [5:0] sx, input logic [5:0] sy,
                               input logic [1:0] d, output wall_t res);
    int nx;
    int ny;
    bit found;
    res = '0;
    if (k == KIND_START) begin
      cur_x = (int'(sx) > cols() - 1) ? cols() - 1 : int'(sx);
      cur_y = (int'(sy) > rows() - 1) ? rows() - 1 : int'(sy);
      seen = '0;
      seen[cur_y * MAX_W + cur_x] = 1'b1;
      seeking = 1'b0;
      carved_out = 1'b0;
      return 1'b0;
    end
    if (carved_out) return 1'b0;
    if (!seeking && shut_dirs(cur_x, cur_y, 1'b0) == ALL_DIRS) begin
      found = 1'b0;
      for (int x = 0; x < cols() && !found; x++) begin
        for (int y = 0; y < rows() && !found; y++) begin
          if (!seen[y * MAX_W + x] && shut_dirs(x, y, 1'b1) != ALL_DIRS) begin
            cur_x = x;
            cur_y = y;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        carved_out = 1'b1;
        res.fin = 1'b1;
        return 1'b1;
      end
      seeking = 1'b1;
    end
    if (seeking) begin
      if (!step_cell(cur_x, cur_y, d, nx, ny) || !seen[ny * MAX_W + nx]) return 1'b0;
      seen[cur_y * MAX_W + cur_x] = 1'b1;
      seeking = 1'b0;
      res.fx = 6'(cur_x);
      res.fy = 6'(cur_y);
      res.od = d;
      return 1'b1;
    end
    if (!step_cell(cur_x, cur_y, d, nx, ny) || seen[ny * MAX_W + nx]) return 1'b0;
    res.fx = 6'(cur_x);
    res.fy = 6'(cur_y);
    res.od = d;
    seen[ny * MAX_W + nx] = 1'b1;
    cur_x = nx;
    cur_y = ny;
    return 1'b1;
  endfunction

  function automatic logic [6:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 7'($urandom_range(0, 1));
    if (r < 12) return 7'($urandom_range(64, 127));
    if (r < 30) return 7'($urandom_range(7, 16));
    return 7'($urandom_range(2, 6));
  endfunction

  task automatic send_item(input logic k, input logic [5:0] sx, input logic [5:0] sy,
                           input logic [1:0] d, input bit tp, input bit t_has,
                           input wall_t t_res);
    bit has;
    wall_t res;
    if (n_items < ITEM_GOAL / 3) begin
      snd_idle = 15;
      rcv_idle = 63;
    end else if (n_items < 2 * ITEM_GOAL / 3) begin
      snd_idle = 63;
      rcv_idle = 15;
    end else begin
      snd_idle = 0;
      rcv_idle = 0;
    end
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    start_x <= sx;
    start_y <= sy;
    draw_dir <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!(k == KIND_DRAW && carved_out)) n_items++;
    has = carve(k, sx, sy, d, res);
    if (tp) begin
      has = t_has;
      res = t_res;
    end
    if (has) wall_q.push_back(res);
  endtask

  // wait until every expected beat is out and the block takes items again
  task automatic settle();
    in_valid <= 1'b0;
    while (wall_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    while (!in_ready) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [6:0] wv, input logic [6:0] hv,
                              input bit wr_w, input bit wr_h);
    settle();
    for (int i = 0; i < 2; i++) begin
      if (i == 0 ? wr_w : wr_h) begin
        cfg_valid <= 1'b1;
        cfg_index <= (i == 0) ? REG_WIDTH : REG_HEIGHT;
        cfg_data <= (i == 0) ? wv : hv;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (i == 0) cols_reg = int'(wv);
        else rows_reg = int'(hv);
        n_cfg++;
      end
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  always @(posedge clk) begin
    wall_t want;
    if (!rst && out_valid && out_ready) begin
      if (wall_q.size() == 0) begin
        $error("result beat with nothing expected: from_x %0d from_y %0d", from_x, from_y);
        errors++;
      end else begin
        want = wall_q.pop_front();
        if (from_x !== want.fx) begin
          $error("from_x: expected %0d, got %0d", want.fx, from_x);
          errors++;
        end
        if (from_y !== want.fy) begin
          $error("from_y: expected %0d, got %0d", want.fy, from_y);
          errors++;
        end
        if (opened_dir !== want.od) begin
          $error("opened_dir: expected %0d, got %0d", want.od, opened_dir);
          errors++;
        end
        if (finished !== want.fin) begin
          $error("finished: expected %0d, got %0d", want.fin, finished);
          errors++;
        end
        if (want.fin) n_fin++;
        else n_walls++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t r;
    logic [5:0] sx;
    logic [5:0] sy;
    int cap;
    int pick;
    bit wr_w;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NROWS; i++) begin
      r = PLAN[i];
      if (r.cfg) program_regs(r.wv, r.hv, 1'b1, 1'b1);
      else send_item(r.kd, r.sx, r.sy, r.d, r.tp, r.has, {r.fx, r.fy, r.od, r.fin});
    end

    while (n_items < ITEM_GOAL) begin
      program_regs(pick_dim(), pick_dim(), 1'b1, 1'b1);
      cap = (cols() * rows() > 100) ? 60 : 300;
      sx = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, cols() - 1));
      sy = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, rows() - 1));
      send_item(KIND_START, sx, sy, DIR_N, 1'b0, 1'b0, '0);
      for (int j = 0; j < cap && !carved_out && n_items < ITEM_GOAL; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          // resize in the middle of a maze
          wr_w = 1'($urandom_range(0, 1));
          program_regs(pick_dim(), pick_dim(), wr_w, !wr_w);
        end else if (pick < 4) begin
          // abandon the maze and start over
          send_item(KIND_START, 6'($urandom), 6'($urandom), 2'($urandom), 1'b0, 1'b0, '0);
        end else begin
          send_item(KIND_DRAW, 6'($urandom), 6'($urandom), 2'($urandom), 1'b0, 1'b0, '0);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3))
          send_item(KIND_DRAW, 6'($urandom), 6'($urandom), 2'($urandom), 1'b0, 1'b0, '0);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (wall_q.size() != 0) begin
      $error("%0d expected results never came out", wall_q.size());
      errors++;
    end
    $display("carver run: %0d items, %0d walls opened, %0d mazes carved to the end",
             n_items, n_walls, n_fin);
    $display("carver run: %0d register writes, grids from clamped 2x2 up to 64x64", n_cfg);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
